FILE: hw/rtl/obbsat_pkg.sv
// Shared types, constants and the per-axis product schedule for the box overlap test.
package obbsat_pkg;

    localparam int SLOTS       = 18;
    localparam int OPS_PER_AXIS = 7;
    localparam logic [3:0] CMP_STEP  = 4'd9;
    localparam logic [3:0] LAST_AXIS = 4'd14;

    typedef enum logic [1:0] {
        DST_RA = 2'd0,
        DST_RB = 2'd1,
        DST_T  = 2'd2
    } t_dst;

    typedef enum logic [1:0] {
        KB_VAL = 2'd0,
        KB_ABS = 2'd1,
        KB_ONE = 2'd2
    } t_kb;

    typedef struct packed {
        logic       en;
        t_dst       dst;
        logic [4:0] sa;
        t_kb        kb;
        logic [4:0] sb;
        logic       neg;
    } t_op;

    typedef struct packed {
        logic issue;
        logic clear;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic sep;
    } t_sts;

    function automatic t_op mk(t_dst d, int a, t_kb k, int b, logic n);
        t_op o;
        o.en  = 1'b1;
        o.dst = d;
        o.sa  = 5'(a);
        o.kb  = k;
        o.sb  = 5'(b);
        o.neg = n;
        return o;
    endfunction

    // Product k of axis ax; unused slots come back with en low.
    function automatic t_op op_at(logic [3:0] ax, logic [2:0] k);
        t_op ops [OPS_PER_AXIS];
        int a, i, j, i1, i2, j1, j2;
        a = int'(ax);
        for (int n = 0; n < OPS_PER_AXIS; n++) begin
            ops[n] = '0;
        end
        if (a < 3) begin
            i = a;
            ops[0] = mk(DST_RA, 12 + i, KB_ONE, 0, 1'b0);
            ops[1] = mk(DST_RB, 15, KB_ABS, 3 * i, 1'b0);
            ops[2] = mk(DST_RB, 16, KB_ABS, 3 * i + 1, 1'b0);
            ops[3] = mk(DST_RB, 17, KB_ABS, 3 * i + 2, 1'b0);
            ops[4] = mk(DST_T, 9 + i, KB_ONE, 0, 1'b0);
        end else if (a < 6) begin
            j = a - 3;
            ops[0] = mk(DST_RA, 12, KB_ABS, j, 1'b0);
            ops[1] = mk(DST_RA, 13, KB_ABS, 3 + j, 1'b0);
            ops[2] = mk(DST_RA, 14, KB_ABS, 6 + j, 1'b0);
            ops[3] = mk(DST_RB, 15 + j, KB_ONE, 0, 1'b0);
            ops[4] = mk(DST_T, 9, KB_VAL, j, 1'b0);
            ops[5] = mk(DST_T, 10, KB_VAL, 3 + j, 1'b0);
            ops[6] = mk(DST_T, 11, KB_VAL, 6 + j, 1'b0);
        end else begin
            // cross axes: row i and column j from compares, neighbors wrap around
            i  = (a >= 12) ? 2 : (a >= 9) ? 1 : 0;
            j  = a - 6 - 3 * i;
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            j1 = (j == 2) ? 0 : j + 1;
            j2 = (j == 0) ? 2 : j - 1;
            ops[0] = mk(DST_RA, 12 + i1, KB_ABS, 3 * i2 + j, 1'b0);
            ops[1] = mk(DST_RA, 12 + i2, KB_ABS, 3 * i1 + j, 1'b0);
            ops[2] = mk(DST_RB, 15 + j1, KB_ABS, 3 * i + j2, 1'b0);
            ops[3] = mk(DST_RB, 15 + j2, KB_ABS, 3 * i + j1, 1'b0);
            ops[4] = mk(DST_T, 9 + i2, KB_VAL, 3 * i1 + j, 1'b0);
            ops[5] = mk(DST_T, 9 + i1, KB_VAL, 3 * i2 + j, 1'b1);
        end
        return (k < 3'(OPS_PER_AXIS)) ? ops[k] : t_op'('0);
    endfunction

endpackage

FILE: hw/rtl/obbsat_datapath.sv
// Operand store, shared multiplier, three accumulators and the separation compare.
module obbsat_datapath #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [4:0]             i_wr_slot,
    input  logic [VALUE_WIDTH-1:0] i_wr_value,
    input  obbsat_pkg::t_cmd       i_cmd,
    output obbsat_pkg::t_sts       o_sts
);
    import obbsat_pkg::*;

    localparam int OW = (VALUE_WIDTH + 1 > FRAC_BITS + 2) ? VALUE_WIDTH + 1 : FRAC_BITS + 2;
    localparam int PW = 2 * OW;
    localparam int AW = PW + 2;

    logic [VALUE_WIDTH-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]       r_vld;
    logic [VALUE_WIDTH-1:0] r_rda, r_rdb;

    logic r_s1_en, r_s1_neg, r_s2_en, r_s2_neg;
    t_dst r_s1_dst, r_s2_dst;
    t_kb  r_s1_kb;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_ra, r_rb, r_t;

    logic signed [OW-1:0] ax, bx, bop;
    logic signed [AW-1:0] pext, n_ra, n_rb, n_t;
    logic signed [AW:0]   sumr;
    logic [AW:0]          abst;

    // store: valid bits make unwritten slots read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en && i_wr_slot < 5'(SLOTS)) begin
            r_vld[i_wr_slot] <= 1'b1;
        end
        if (i_wr_en && i_wr_slot < 5'(SLOTS)) begin
            r_mem[i_wr_slot] <= i_wr_value;
        end
        r_rda <= r_vld[i_cmd.op.sa] ? r_mem[i_cmd.op.sa] : '0;
        r_rdb <= r_vld[i_cmd.op.sb] ? r_mem[i_cmd.op.sb] : '0;
    end

    always_comb begin
        ax = {{(OW-VALUE_WIDTH){r_rda[VALUE_WIDTH-1]}}, r_rda};
        bx = {{(OW-VALUE_WIDTH){r_rdb[VALUE_WIDTH-1]}}, r_rdb};
        case (r_s1_kb)
            KB_VAL:  bop = bx;
            KB_ABS:  bop = bx[OW-1] ? -bx : bx;
            KB_ONE:  bop = OW'(1) << FRAC_BITS;
            default: bop = bx;
        endcase
        pext = {{2{r_prod[PW-1]}}, r_prod};
        n_ra = r_ra;
        n_rb = r_rb;
        n_t  = r_t;
        if (i_cmd.clear) begin
            n_ra = '0;
            n_rb = '0;
            n_t  = '0;
        end else if (r_s2_en) begin
            case (r_s2_dst)
                DST_RA:  n_ra = r_s2_neg ? r_ra - pext : r_ra + pext;
                DST_RB:  n_rb = r_s2_neg ? r_rb - pext : r_rb + pext;
                DST_T:   n_t  = r_s2_neg ? r_t - pext : r_t + pext;
                default: n_t  = r_t;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_en <= 1'b0;
            r_s2_en <= 1'b0;
        end else begin
            r_s1_en <= i_cmd.issue && i_cmd.op.en;
            r_s2_en <= r_s1_en;
        end
        r_s1_dst <= i_cmd.op.dst;
        r_s1_kb  <= i_cmd.op.kb;
        r_s1_neg <= i_cmd.op.neg;
        r_s2_dst <= r_s1_dst;
        r_s2_neg <= r_s1_neg;
        r_prod   <= ax * bop;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_t      <= n_t;
    end

    assign sumr = {r_ra[AW-1], r_ra} + {r_rb[AW-1], r_rb};
    assign abst = r_t[AW-1] ? -{r_t[AW-1], r_t} : {r_t[AW-1], r_t};
    assign o_sts.sep = $signed({1'b0, abst}) > $signed({sumr[AW], sumr});

endmodule

FILE: hw/rtl/obbsat_ctrl.sv
// Sequencer over the 15 axes and the result register.
module obbsat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  obbsat_pkg::t_sts i_sts,
    input  logic             i_out_ready,
    output logic             o_idle,
    output obbsat_pkg::t_cmd o_cmd,
    output logic             o_out_valid,
    output logic             o_out_overlap
);
    import obbsat_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_axis, n_axis, r_step, n_step;
    logic r_res, n_res, r_ovalid, n_ovalid, r_overlap, n_overlap;

    always_comb begin
        n_state   = r_state;
        n_axis    = r_axis;
        n_step    = r_step;
        n_res     = r_res;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_overlap = r_overlap;
        o_cmd       = '0;
        o_cmd.op    = op_at(r_axis, r_step[2:0]);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.clear = 1'b1;
                    n_axis  = '0;
                    n_step  = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = r_step < 4'(OPS_PER_AXIS);
                if (r_step == CMP_STEP) begin
                    if (i_sts.sep || r_axis == LAST_AXIS) begin
                        n_res   = !i_sts.sep;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_axis = r_axis + 4'd1;
                        n_step = '0;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid  = 1'b1;
                    n_overlap = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_axis   <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_axis   <= n_axis;
            r_step   <= n_step;
        end
        r_res     <= n_res;
        r_overlap <= n_overlap;
    end

    assign o_idle        = r_state == S_IDLE;
    assign o_out_valid   = r_ovalid;
    assign o_out_overlap = r_overlap;

endmodule

FILE: hw/rtl/obb_overlap_separating_axis.sv
// Top level of the oriented box overlap test over all 15 separating axes.
// Use:
//   Input channel (i_valid / o_ready) carries one word per item: i_slot picks
//   one of 18 operand slots, i_value is the signed fixed-point value, and
//   i_last starts the overlap test once the value is stored. Slots 18-31
//   store nothing. Stored values persist across tests.
//   Output channel (o_valid / i_ready) carries one word, o_overlap, for each
//   item marked last; touching boxes count as overlapping.
// Sequencing:
//   A load without last leaves o_ready high, so words without last can follow
//   back to back. A test runs axis by axis: up to seven products through the
//   one shared multiplier (store read, multiply, accumulate stages) and a compare.
//   It stops at the first separating axis; the done state then moves the verdict
//   into the output register once that register is free, and o_ready stays low
//   from the accepting edge until that move.
// Reset:
//   i_rst_n low makes every operand slot read as zero and drops o_valid.
// Stall:
//   The result sits in an output register; loads are taken while it waits.
//   A further test that finishes before it is taken holds until i_ready.
module obb_overlap_separating_axis #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [4:0]             i_slot,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_overlap
);
    import obbsat_pkg::*;

    logic acc_in, idle;
    t_cmd cmd;
    t_sts sts;

    assign o_ready = idle;
    assign acc_in  = i_valid && idle;

    obbsat_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (acc_in && i_last),
        .i_sts         (sts),
        .i_out_ready   (i_ready),
        .o_idle        (idle),
        .o_cmd         (cmd),
        .o_out_valid   (o_valid),
        .o_out_overlap (o_overlap)
    );

    obbsat_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (acc_in),
        .i_wr_slot  (i_slot),
        .i_wr_value (i_value),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

FILE: hw/rtl/obbsat_checker.sv
// Port-level assertions for the overlap block and their bind.
module obbsat_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic i_last,
    input logic o_valid,
    input logic i_ready,
    input logic o_overlap
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_overlap))
        else $error("result dropped or changed while stalled");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last |=> !o_ready)
        else $error("input taken while a test runs");

    a_result_after_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result without a running test");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind obb_overlap_separating_axis obbsat_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .i_last    (i_last),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_overlap (o_overlap)
);

FILE: dv/testbench.sv
// Self-checking testbench for the oriented box overlap test over 15 separating axes.
`timescale 1ns / 1ps

module testbench;

    localparam int VW          = 32;
    localparam int FB          = 16;
    localparam int NUM_SLOTS   = 18;
    localparam int RANDOM_SETS = 170;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [4:0]    slot;
        logic [VW-1:0] value;
        logic          last;
    } t_word;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [4:0]    i_slot;
    logic [VW-1:0] i_value;
    logic          i_last;
    logic          o_valid;
    logic          i_ready;
    logic          o_overlap;

    obb_overlap_separating_axis #(
        .VALUE_WIDTH(VW),
        .FRAC_BITS  (FB)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_slot   (i_slot),
        .i_value  (i_value),
        .i_last   (i_last),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_overlap(o_overlap)
    );

    // Predictor state: a copy of the operand store.
    logic signed [VW-1:0] box_slots [NUM_SLOTS];

    t_word pending_words [$];
    logic  overlap_due [$];

    int  mismatches;
    int  results_seen;
    int  tests_sent;
    bit  hold_sink;
    bit  pause_src;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Projected extents use 128-bit signed math; every term is exact.
    function automatic logic signed [127:0] wmul(logic signed [VW-1:0] a,
                                                 logic signed [VW:0] b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // One extra bit so the most negative value has a magnitude.
    function automatic logic signed [VW:0] absv(logic signed [VW:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [VW:0] rot_at(int i, int j);
        return (VW + 1)'(box_slots[3 * i + j]);
    endfunction

    function automatic logic signed [VW:0] arot_at(int i, int j);
        return absv(rot_at(i, j));
    endfunction

    function automatic bit axis_separates(logic signed [127:0] t,
                                          logic signed [127:0] ra,
                                          logic signed [127:0] rb);
        logic signed [127:0] at;
        at = (t < 0) ? -t : t;
        return at > ra + rb;
    endfunction

    function automatic bit boxes_overlap();
        logic signed [VW:0]   one;
        logic signed [127:0]  ra;
        logic signed [127:0]  rb;
        logic signed [127:0]  t;
        int i1, i2, j1, j2;
        one = (VW + 1)'(1) << FB;
        for (int i = 0; i < 3; i++) begin
            ra = wmul(box_slots[12 + i], one);
            rb = wmul(box_slots[15], arot_at(i, 0)) + wmul(box_slots[16], arot_at(i, 1))
               + wmul(box_slots[17], arot_at(i, 2));
            t  = wmul(box_slots[9 + i], one);
            if (axis_separates(t, ra, rb)) return 1'b0;
        end
        for (int j = 0; j < 3; j++) begin
            ra = wmul(box_slots[12], arot_at(0, j)) + wmul(box_slots[13], arot_at(1, j))
               + wmul(box_slots[14], arot_at(2, j));
            rb = wmul(box_slots[15 + j], one);
            t  = wmul(box_slots[9], rot_at(0, j)) + wmul(box_slots[10], rot_at(1, j))
               + wmul(box_slots[11], rot_at(2, j));
            if (axis_separates(t, ra, rb)) return 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                ra = wmul(box_slots[12 + i1], arot_at(i2, j))
                   + wmul(box_slots[12 + i2], arot_at(i1, j));
                rb = wmul(box_slots[15 + j1], arot_at(i, j2))
                   + wmul(box_slots[15 + j2], arot_at(i, j1));
                t  = wmul(box_slots[9 + i2], rot_at(i1, j))
                   - wmul(box_slots[9 + i1], rot_at(i2, j));
                if (axis_separates(t, ra, rb)) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Apply one accepted word to the store copy; queue the verdict on last.
    task automatic absorb_word(t_word w);
        if (w.slot < NUM_SLOTS) box_slots[w.slot] = w.value;
        if (w.last) begin
            overlap_due.push_back(boxes_overlap());
            tests_sent++;
        end
    endtask

    task automatic push_word(int slot, logic [VW-1:0] value, bit last);
        t_word w;
        w.slot  = 5'(slot);
        w.value = value;
        w.last  = last;
        pending_words.push_back(w);
    endtask

    // Mostly small fixed-point magnitudes so tests land on both sides.
    function automatic logic [VW-1:0] pick_value(bit is_dim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return $urandom();
        if (r < 7) return {1'b1, {(VW - 1){1'b0}}};
        if (r < 10) return {1'b0, {(VW - 1){1'b1}}};
        if (is_dim && r < 90) return VW'($urandom_range(0, 4 << FB));
        return VW'($signed($urandom_range(0, 8 << FB)) - $signed(4 << FB));
    endfunction

    task automatic push_random_box();
        int order [NUM_SLOTS];
        int n;
        int tmp;
        int k;
        n = $urandom_range(1, NUM_SLOTS);
        for (int s = 0; s < NUM_SLOTS; s++) order[s] = s;
        for (int s = NUM_SLOTS - 1; s > 0; s--) begin
            k = $urandom_range(0, s);
            tmp = order[s];
            order[s] = order[k];
            order[k] = tmp;
        end
        for (int s = 0; s < n; s++) begin
            push_word(order[s], pick_value(order[s] >= 12), 1'b0);
        end
        // End either on a real slot or on an out-of-range one.
        if ($urandom_range(0, 9) == 0) begin
            push_word($urandom_range(NUM_SLOTS, 31), $urandom(), 1'b1);
        end else begin
            k = $urandom_range(0, NUM_SLOTS - 1);
            push_word(k, pick_value(k >= 12), 1'b1);
        end
    endtask

    // Identity rotation, unit boxes, centre offset c along x.
    task automatic push_aligned(logic [VW-1:0] cx, bit last);
        for (int s = 0; s < 9; s++) begin
            push_word(s, (s % 4 == 0) ? VW'(1 << FB) : '0, 1'b0);
        end
        push_word(10, '0, 1'b0);
        push_word(11, '0, 1'b0);
        for (int s = 12; s < 18; s++) push_word(s, VW'(1 << FB), 1'b0);
        push_word(9, cx, last);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || overlap_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Handshake seen at the last rising edge.
    logic o_ready_seen;

    // Sender: drive at the falling edge, with random gaps.
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (i_valid && !(o_ready_seen)) begin
            // hold the word until it is taken
        end else if (pause_src || pending_words.size() == 0) begin
            i_valid <= 1'b0;
        end else if (gap_left > 0) begin
            i_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else begin
            i_valid  <= 1'b1;
            i_slot   <= pending_words[0].slot;
            i_value  <= pending_words[0].value;
            i_last   <= pending_words[0].last;
            gap_left <= ($urandom_range(0, 3) != 0) ? 0 :
                        ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        end
    end

    // Pop the word the sender offered once it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ready_seen <= 1'b0;
        end else begin
            o_ready_seen <= i_valid && o_ready;
            if (i_valid && o_ready) absorb_word(pending_words.pop_front());
        end
    end

    // Receiver: random stalls, and a long forced hold when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_sink) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 3) != 0) ? 1'b1 :
                        ($urandom_range(0, 7) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (overlap_due.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result overlap=%0b", o_overlap);
            end else if (overlap_due[0] !== o_overlap) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) begin
                    $display("result %0d: expected overlap=%0b, got %0b",
                             results_seen, overlap_due[0], o_overlap);
                end
                void'(overlap_due.pop_front());
            end else begin
                void'(overlap_due.pop_front());
            end
        end
    end

    // Long receiver hold, counted in its own process.
    initial begin
        hold_sink = 1'b0;
        wait (tests_sent >= 20);
        @(negedge i_clk);
        hold_sink = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_sink = 1'b0;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_slot      = '0;
        i_value     = '0;
        i_last      = 1'b0;
        pause_src   = 1'b0;
        mismatches  = 0;
        results_seen = 0;
        tests_sent  = 0;
        for (int s = 0; s < NUM_SLOTS; s++) box_slots[s] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: all-zero store after reset, touching, just apart, overlap, then extreme and out-of-range words.
        push_word(0, '0, 1'b1);
        push_aligned(VW'(2 << FB), 1'b1);
        push_word(9, VW'((2 << FB) + 1), 1'b1);
        push_word(9, VW'(-(2 << FB)), 1'b1);
        push_word(9, VW'(1 << FB), 1'b1);
        push_word(12, VW'(-(1 << FB)), 1'b1);
        push_word(31, {1'b1, {(VW - 1){1'b0}}}, 1'b1);
        push_word(12, {1'b0, {(VW - 1){1'b1}}}, 1'b0);
        push_word(4, {1'b1, {(VW - 1){1'b0}}}, 1'b1);
        push_word(18, {(VW){1'b1}}, 1'b0);
        push_word(17, {(VW){1'b1}}, 1'b1);
        wait_drained();

        // Sender pause once everything has come back.
        pause_src = 1'b1;
        repeat (200) @(posedge i_clk);
        pause_src = 1'b0;

        for (int n = 0; n < RANDOM_SETS; n++) begin
            if ($urandom_range(0, 9) == 0) push_word($urandom_range(0, 31), $urandom(), 1'b0);
            push_random_box();
            while (pending_words.size() > 40) @(posedge i_clk);
        end
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("Covered %0d overlap tests over loaded operand sets, %0d verdicts checked.",
                 tests_sent, results_seen);
        if (mismatches == 0 && overlap_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/obbsat_pkg.sv
hw/rtl/obbsat_datapath.sv
hw/rtl/obbsat_ctrl.sv
hw/rtl/obb_overlap_separating_axis.sv
hw/rtl/obbsat_checker.sv
dv/testbench.sv
